// File: design/etff_pkg.sv
// ============================================================================
// etff_pkg: shared types and constants for the extent table first-fit unit
// Holds request and result codes, field layout of the stream words and the
// command/status bundles between controller and datapath.
// ============================================================================
package etff_pkg;

    // Stream word layout
    localparam int FUNC_W     = 2;
    localparam int KEY_W      = 32;
    localparam int LEN_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int OFFS_W     = 16;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 56;

    localparam int S_FUNC_LSB = 0;
    localparam int S_KEY_LSB  = 2;
    localparam int S_LEN_LSB  = 34;

    localparam int M_STAT_LSB = 0;
    localparam int M_OFFS_LSB = 2;
    localparam int M_GRNT_LSB = 18;
    localparam int M_USED_LSB = 34;

    // Top key byte values that mark an empty or erased slot
    localparam logic [7:0] KEY_BYTE_EMPTY  = 8'h00;
    localparam logic [7:0] KEY_BYTE_ERASED = 8'hFF;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_READ   = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NO_SPACE  = 2'd3
    } status_t;

    // How the datapath fills offset and granted of a result
    typedef enum logic [1:0] {
        RES_ZERO    = 2'd0,
        RES_READ    = 2'd1,
        RES_INPLACE = 2'd2,
        RES_NEW     = 2'd3
    } res_kind_t;

    typedef struct packed {
        logic      load;       // capture the input word
        logic      match;      // compare key against every slot
        logic      select;     // encode lowest matching slot
        logic      clear_all;  // empty the table
        logic      shrink;     // rewrite length of matched slot in place
        logic      drop;       // free the matched slot
        logic      find_free;  // encode lowest free slot, reset candidate
        logic      fit_cmp;    // overlap test of candidate against all slots
        logic      fit_step;   // jump candidate past lowest overlapping extent
        logic      place;      // write new extent into free slot
        logic      set_res;    // capture result fields
        res_kind_t res_kind;
        status_t   res_status;
        logic      out_load;   // move result into output register
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  key_ok;
        logic  len_zero;
        logic  len_over;
        logic  found;
        logic  fits_in_place;
        logic  free_found;
        logic  fit_over;
        logic  fit_hit;
    } stat_t;

    function automatic logic key_live(input logic [KEY_W-1:0] k);
        logic [7:0] top;
        top = k[KEY_W-1 -: 8];
        return (top != KEY_BYTE_EMPTY) && (top != KEY_BYTE_ERASED);
    endfunction

endpackage

// File: design/etff_dp.sv
// ============================================================================
// etff_dp: extent table datapath
// Slot table, key match, free-slot and first-fit search, used-byte count and
// result/output registers, all driven by controller commands.
// ============================================================================
module etff_dp #(
    parameter int SLOTS      = 16,
    parameter int AREA_BYTES = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [etff_pkg::FUNC_W-1:0]         in_func,
    input  logic [etff_pkg::KEY_W-1:0]          in_key,
    input  logic [etff_pkg::LEN_W-1:0]          in_length,
    input  etff_pkg::cmd_t                      cmd,
    output etff_pkg::stat_t                     stat,
    output logic [etff_pkg::STATUS_W-1:0]       out_status,
    output logic [etff_pkg::OFFS_W-1:0]         out_offset,
    output logic [etff_pkg::LEN_W-1:0]          out_granted,
    output logic [etff_pkg::LEN_W-1:0]          out_used
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW    = etff_pkg::LEN_W;
    localparam int KW    = etff_pkg::KEY_W;

    // Request
    logic [etff_pkg::FUNC_W-1:0] func_reg;
    logic [KW-1:0]               key_reg;
    logic [LW-1:0]               len_reg;

    // Slot table
    logic [KW-1:0] slot_key_reg   [SLOTS];
    logic [LW-1:0] slot_start_reg [SLOTS];
    logic [LW-1:0] slot_len_reg   [SLOTS];

    // Search state
    logic [SLOTS-1:0] match_reg;
    logic             found_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [LW:0]      cand_reg;
    logic [LW:0]      cand_next;
    logic [SLOTS-1:0] hit_reg;
    logic [LW-1:0]    used_reg;
    logic [LW-1:0]    used_next;

    // Result and output
    logic [etff_pkg::STATUS_W-1:0] res_status_reg;
    logic [LW-1:0]                 res_offs_reg;
    logic [LW-1:0]                 res_grnt_reg;
    logic [etff_pkg::STATUS_W-1:0] out_status_reg;
    logic [LW-1:0]                 out_offs_reg;
    logic [LW-1:0]                 out_grnt_reg;
    logic [LW-1:0]                 out_used_reg;

    // Combinational search results
    logic [SLOTS-1:0] match_vec;
    logic [SLOTS-1:0] hit_vec;
    logic             found_c;
    logic [IDX_W-1:0] found_idx_c;
    logic             free_c;
    logic [IDX_W-1:0] free_idx_c;
    logic [IDX_W-1:0] hit_idx_c;
    logic [LW-1:0]    idx_len;
    logic [LW-1:0]    idx_start;
    logic [LW+1:0]    cand_end;

    assign idx_len   = slot_len_reg[idx_reg];
    assign idx_start = slot_start_reg[idx_reg];
    assign cand_end  = {1'b0, cand_reg} + {2'b00, len_reg};

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match_vec[i] = (slot_key_reg[i] == key_reg);
            hit_vec[i]   = etff_pkg::key_live(slot_key_reg[i])
                         && (cand_reg < ({1'b0, slot_start_reg[i]} + {1'b0, slot_len_reg[i]}))
                         && ({2'b00, slot_start_reg[i]} < cand_end);
        end
    end

    // Priority encoders: lowest index wins
    always_comb
    begin
        found_c     = 1'b0;
        found_idx_c = '0;
        free_c      = 1'b0;
        free_idx_c  = '0;
        hit_idx_c   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                found_c     = 1'b1;
                found_idx_c = IDX_W'(i);
            end
            if (!etff_pkg::key_live(slot_key_reg[i]))
            begin
                free_c     = 1'b1;
                free_idx_c = IDX_W'(i);
            end
            if (hit_reg[i])
            begin
                hit_idx_c = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        cand_next = cand_reg;
        if (cmd.find_free)
        begin
            cand_next = '0;
        end
        else if (cmd.fit_step)
        begin
            cand_next = {1'b0, slot_start_reg[hit_idx_c]} + {1'b0, slot_len_reg[hit_idx_c]};
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (cmd.clear_all)
        begin
            used_next = '0;
        end
        else if (cmd.shrink)
        begin
            used_next = used_reg - idx_len + len_reg;
        end
        else if (cmd.drop)
        begin
            used_next = used_reg - idx_len;
        end
        else if (cmd.place)
        begin
            used_next = used_reg + len_reg;
        end
    end

    // Status to controller
    always_comb
    begin
        stat.func          = etff_pkg::func_t'(func_reg);
        stat.key_ok        = etff_pkg::key_live(key_reg);
        stat.len_zero      = (len_reg == '0);
        stat.len_over      = (len_reg > LW'(AREA_BYTES));
        stat.found         = found_reg;
        stat.fits_in_place = (idx_len >= len_reg);
        stat.free_found    = free_found_reg;
        stat.fit_over      = (cand_end > (LW+2)'(AREA_BYTES));
        stat.fit_hit       = |hit_reg;
    end

    // Slot keys: cleared at reset and by clear table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_key_reg[i] <= '0;
            end
        end
        else if (cmd.clear_all)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_key_reg[i] <= '0;
            end
        end
        else if (cmd.drop)
        begin
            slot_key_reg[idx_reg] <= '0;
        end
        else if (cmd.place)
        begin
            slot_key_reg[free_idx_reg] <= key_reg;
        end
    end

    // Extent bounds are only looked at for live slots
    always_ff @(posedge clk)
    begin
        if (cmd.shrink)
        begin
            slot_len_reg[idx_reg] <= len_reg;
        end
        else if (cmd.place)
        begin
            slot_start_reg[free_idx_reg] <= cand_reg[LW-1:0];
            slot_len_reg[free_idx_reg]   <= len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_func;
            key_reg  <= in_key;
            len_reg  <= in_length;
        end
        if (cmd.match)
        begin
            match_reg <= match_vec;
        end
        if (cmd.select)
        begin
            found_reg <= found_c;
            idx_reg   <= found_idx_c;
        end
        if (cmd.find_free)
        begin
            free_found_reg <= free_c;
            free_idx_reg   <= free_idx_c;
        end
        if (cmd.fit_cmp)
        begin
            hit_reg <= hit_vec;
        end
        cand_reg <= cand_next;
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
            case (cmd.res_kind)
                etff_pkg::RES_READ:
                begin
                    res_offs_reg <= idx_start;
                    res_grnt_reg <= (len_reg < idx_len) ? len_reg : idx_len;
                end
                etff_pkg::RES_INPLACE:
                begin
                    res_offs_reg <= idx_start;
                    res_grnt_reg <= len_reg;
                end
                etff_pkg::RES_NEW:
                begin
                    res_offs_reg <= cand_reg[LW-1:0];
                    res_grnt_reg <= len_reg;
                end
                default:
                begin
                    res_offs_reg <= '0;
                    res_grnt_reg <= '0;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_offs_reg   <= res_offs_reg;
            out_grnt_reg   <= res_grnt_reg;
            out_used_reg   <= used_reg;
        end
    end

    assign out_status  = out_status_reg;
    assign out_offset  = out_offs_reg;
    assign out_granted = out_grnt_reg;
    assign out_used    = out_used_reg;

endmodule

// File: design/etff_ctrl.sv
// ============================================================================
// etff_ctrl: extent table controller
// Sequences lookup, in-place update, drop, free-slot search and the first-fit
// loop, and owns the output valid flag.
// ============================================================================
module etff_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  etff_pkg::stat_t stat,
    output etff_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        IDLE,
        CHECK,
        SELECT,
        DECIDE,
        FREE,
        FIT_CMP,
        FIT_SEL,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   valid_reg;
    logic   valid_next;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        valid_next = valid_reg && !m_tready;
        case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = CHECK;
                end
            end
            CHECK:
            begin
                cmd.match  = 1'b1;
                state_next = SELECT;
            end
            SELECT:
            begin
                cmd.select = 1'b1;
                state_next = DECIDE;
            end
            DECIDE:
            begin
                cmd.set_res    = 1'b1;
                cmd.res_kind   = etff_pkg::RES_ZERO;
                cmd.res_status = etff_pkg::ST_OK;
                state_next     = FINISH;
                if (stat.func == etff_pkg::FUNC_CLEAR)
                begin
                    cmd.clear_all = 1'b1;
                end
                else if (!stat.key_ok)
                begin
                    cmd.res_status = etff_pkg::ST_INVALID;
                end
                else
                begin
                    case (stat.func)
                        etff_pkg::FUNC_READ:
                        begin
                            if (stat.len_zero)
                            begin
                                cmd.res_status = etff_pkg::ST_INVALID;
                            end
                            else if (!stat.found)
                            begin
                                cmd.res_status = etff_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                cmd.res_kind = etff_pkg::RES_READ;
                            end
                        end
                        etff_pkg::FUNC_WRITE:
                        begin
                            if (stat.len_zero || stat.len_over)
                            begin
                                cmd.res_status = etff_pkg::ST_INVALID;
                            end
                            else if (stat.found && stat.fits_in_place)
                            begin
                                cmd.shrink   = 1'b1;
                                cmd.res_kind = etff_pkg::RES_INPLACE;
                            end
                            else
                            begin
                                cmd.set_res = 1'b0;
                                cmd.drop    = stat.found;
                                state_next  = FREE;
                            end
                        end
                        etff_pkg::FUNC_REMOVE:
                        begin
                            if (!stat.found)
                            begin
                                cmd.res_status = etff_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                cmd.drop = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.set_res = 1'b1;
                        end
                    endcase
                end
            end
            FREE:
            begin
                cmd.find_free = 1'b1;
                state_next    = FIT_CMP;
            end
            FIT_CMP:
            begin
                if (!stat.free_found || stat.fit_over)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_kind   = etff_pkg::RES_ZERO;
                    cmd.res_status = etff_pkg::ST_NO_SPACE;
                    state_next     = FINISH;
                end
                else
                begin
                    cmd.fit_cmp = 1'b1;
                    state_next  = FIT_SEL;
                end
            end
            FIT_SEL:
            begin
                if (stat.fit_hit)
                begin
                    cmd.fit_step = 1'b1;
                    state_next   = FIT_CMP;
                end
                else
                begin
                    cmd.place      = 1'b1;
                    cmd.set_res    = 1'b1;
                    cmd.res_kind   = etff_pkg::RES_NEW;
                    cmd.res_status = etff_pkg::ST_OK;
                    state_next     = FINISH;
                end
            end
            FINISH:
            begin
                // hold until the output register is free or being drained
                if (!valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// File: design/extent_table_first_fit_unit.sv
// ============================================================================
// extent_table_first_fit_unit: named extent table with first-fit placement
// Top level joining the controller and the datapath to the stream ports.
// ============================================================================
// Usage:
//   Slave channel (s_*) takes one request word: func, key, length. Master
//   channel (m_*) returns exactly one result word per request: status,
//   offset, granted and used_bytes (live bytes after the request).
//   A request is taken only while the unit is idle; one request is worked at
//   a time.
//   Sequence from accept to m_tvalid: read, remove, clear, in-place write
//   and any rejected request pass CHECK, SELECT, DECIDE and FINISH. Any
//   other write goes from DECIDE to FREE and the first-fit loop, which makes
//   at most SLOTS-1 jumps and leaves for FINISH from FIT_SEL when it places
//   the extent, or from FIT_CMP when no slot is free or area runs out. Each
//   jump tests the candidate against all slots in parallel (FIT_CMP), then
//   picks the lowest overlapping extent and jumps past it (FIT_SEL). The
//   next request can be taken in the cycle after the result is loaded.
//   Results sit in an output register: a request may be accepted while the
//   previous result still waits, and its result holds inside until m_tready
//   drains the register. A stalled receiver thus blocks at most one request.
//   Reset empties the table at once (all keys zero) and clears used_bytes;
//   no clearing pass is needed.
// ============================================================================
module extent_table_first_fit_unit #(
    parameter int SLOTS      = 16,
    parameter int AREA_BYTES = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata fields from bit 0: func[1:0], key[33:2], length[49:34], zero pad
    input  logic [etff_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata fields from bit 0: status[1:0], offset[17:2], granted[33:18],
    // used_bytes[49:34], zero pad
    output logic [etff_pkg::M_TDATA_W-1:0]   m_tdata
);

    etff_pkg::cmd_t  cmd;
    etff_pkg::stat_t stat;

    logic [etff_pkg::STATUS_W-1:0] res_status;
    logic [etff_pkg::OFFS_W-1:0]   res_offset;
    logic [etff_pkg::LEN_W-1:0]    res_granted;
    logic [etff_pkg::LEN_W-1:0]    res_used;

    etff_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    etff_dp #(
        .SLOTS      (SLOTS),
        .AREA_BYTES (AREA_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_func     (s_tdata[etff_pkg::S_FUNC_LSB +: etff_pkg::FUNC_W]),
        .in_key      (s_tdata[etff_pkg::S_KEY_LSB  +: etff_pkg::KEY_W]),
        .in_length   (s_tdata[etff_pkg::S_LEN_LSB  +: etff_pkg::LEN_W]),
        .cmd         (cmd),
        .stat        (stat),
        .out_status  (res_status),
        .out_offset  (res_offset),
        .out_granted (res_granted),
        .out_used    (res_used)
    );

    // Pack result word, top bits padded with zero
    always_comb
    begin
        m_tdata = '0;
        m_tdata[etff_pkg::M_STAT_LSB +: etff_pkg::STATUS_W] = res_status;
        m_tdata[etff_pkg::M_OFFS_LSB +: etff_pkg::OFFS_W]   = res_offset;
        m_tdata[etff_pkg::M_GRNT_LSB +: etff_pkg::LEN_W]    = res_granted;
        m_tdata[etff_pkg::M_USED_LSB +: etff_pkg::LEN_W]    = res_used;
    end

endmodule

// File: design/etff_checker.sv
// ============================================================================
// etff_checker: port-level checks for the extent table first-fit unit
// Watches the stream ports over time; bound onto the top level below.
// ============================================================================
module etff_checker #(
    parameter int AREA_BYTES = 4096
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [etff_pkg::M_TDATA_W-1:0] m_tdata
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // One request at a time: busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while a request is in work");

    // Failed requests carry no offset and no grant
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[etff_pkg::M_STAT_LSB +: etff_pkg::STATUS_W] != etff_pkg::ST_OK)
        |-> (m_tdata[etff_pkg::M_OFFS_LSB +: etff_pkg::OFFS_W] == '0)
            && (m_tdata[etff_pkg::M_GRNT_LSB +: etff_pkg::LEN_W] == '0))
        else $error("failed request reports offset or grant");

    // Live extents never exceed the data area
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[etff_pkg::M_USED_LSB +: etff_pkg::LEN_W] <= 16'(AREA_BYTES)))
        else $error("used byte count beyond data area");

endmodule

bind extent_table_first_fit_unit etff_checker #(
    .AREA_BYTES (AREA_BYTES)
) u_etff_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: sim/extent_table_first_fit_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// extent_table_first_fit_unit_tb: self-checking bench for the extent table
// Drives request words (read, write, remove, clear) through the slave stream.
// Predicts every result word from a local copy of the extent table. Compares
// each result field by field against the oldest pending prediction. The
// random traffic runs in episodes that start from an empty table, so slot
// exhaustion, fragmentation and failed placements all get exercised.
// ============================================================================

typedef struct packed {
    etff_pkg::status_t           status;
    logic [etff_pkg::OFFS_W-1:0] offset;
    logic [etff_pkg::LEN_W-1:0]  granted;
    logic [etff_pkg::LEN_W-1:0]  used;
} extent_result_t;

// Shadow extent table plus the queue of results it predicts
class extent_scoreboard #(int SLOTS = 16, int AREA_BYTES = 4096);
    logic [etff_pkg::KEY_W-1:0]  tab_key   [SLOTS];
    logic [etff_pkg::OFFS_W-1:0] tab_start [SLOTS];
    logic [etff_pkg::LEN_W-1:0]  tab_len   [SLOTS];
    extent_result_t              pending_q [$];
    int failures;
    int results_checked;
    int func_cnt   [4];
    int status_cnt [4];
    int deepest_jumps;

    function new();
        failures = 0;
        results_checked = 0;
        deepest_jumps = 0;
        foreach (func_cnt[i])
        begin
            func_cnt[i] = 0;
            status_cnt[i] = 0;
        end
        wipe();
    endfunction

    function void wipe();
        foreach (tab_key[i])
            drop(i);
    endfunction

    function void drop(int i);
        tab_key[i]   = '0;
        tab_start[i] = '0;
        tab_len[i]   = '0;
    endfunction

    function bit named(logic [etff_pkg::KEY_W-1:0] k);
        logic [7:0] top;
        top = k[etff_pkg::KEY_W-1 -: 8];
        return (top != etff_pkg::KEY_BYTE_EMPTY) && (top != etff_pkg::KEY_BYTE_ERASED);
    endfunction

    function int lookup(logic [etff_pkg::KEY_W-1:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (tab_key[i] == k) return i;
        return -1;
    endfunction

    function int lowest_free();
        for (int i = 0; i < SLOTS; i++)
            if (!named(tab_key[i])) return i;
        return -1;
    endfunction

    // Jump the candidate past the lowest-numbered overlapping extent
    function bit first_fit(int unsigned len, output int unsigned where);
        int unsigned cand;
        int unsigned e;
        int jumps;
        bit hit;
        cand = 0;
        jumps = 0;
        where = 0;
        while (cand + len <= AREA_BYTES)
        begin
            hit = 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (named(tab_key[i]))
                begin
                    e = 32'(tab_start[i]) + 32'(tab_len[i]);
                    if (cand < e && 32'(tab_start[i]) < cand + len)
                    begin
                        hit = 1'b1;
                        cand = e;
                        break;
                    end
                end
            end
            if (!hit)
            begin
                where = cand;
                if (jumps > deepest_jumps) deepest_jumps = jumps;
                return 1'b1;
            end
            jumps++;
        end
        if (jumps > deepest_jumps) deepest_jumps = jumps;
        return 1'b0;
    endfunction

    function logic [etff_pkg::LEN_W-1:0] used_total();
        int unsigned t;
        t = 0;
        for (int i = 0; i < SLOTS; i++)
            if (named(tab_key[i])) t += 32'(tab_len[i]);
        return (t > 32'hFFFF) ? 16'hFFFF : t[etff_pkg::LEN_W-1:0];
    endfunction

    // Apply one accepted request to the shadow table and queue its result
    function void note_request(etff_pkg::func_t f, logic [etff_pkg::KEY_W-1:0] k,
                               logic [etff_pkg::LEN_W-1:0] len);
        extent_result_t r;
        int idx;
        int fs;
        int unsigned where;
        r.status  = etff_pkg::ST_OK;
        r.offset  = '0;
        r.granted = '0;
        func_cnt[f]++;
        if (f == etff_pkg::FUNC_CLEAR)
        begin
            wipe();
        end
        else if (!named(k))
        begin
            r.status = etff_pkg::ST_INVALID;
        end
        else if (f == etff_pkg::FUNC_READ)
        begin
            idx = lookup(k);
            if (len == 0)
            begin
                r.status = etff_pkg::ST_INVALID;
            end
            else if (idx < 0)
            begin
                r.status = etff_pkg::ST_NOT_FOUND;
            end
            else
            begin
                r.offset  = tab_start[idx];
                r.granted = (len < tab_len[idx]) ? len : tab_len[idx];
            end
        end
        else if (f == etff_pkg::FUNC_WRITE)
        begin
            if (len == 0 || 32'(len) > AREA_BYTES)
            begin
                r.status = etff_pkg::ST_INVALID;
            end
            else
            begin
                idx = lookup(k);
                if (idx >= 0 && tab_len[idx] >= len)
                begin
                    // shrink in place
                    tab_len[idx] = len;
                    r.offset  = tab_start[idx];
                    r.granted = len;
                end
                else
                begin
                    // old extent goes away even when the new one will not fit
                    if (idx >= 0) drop(idx);
                    fs = lowest_free();
                    if (fs < 0 || !first_fit(32'(len), where))
                    begin
                        r.status = etff_pkg::ST_NO_SPACE;
                    end
                    else
                    begin
                        tab_key[fs]   = k;
                        tab_start[fs] = where[etff_pkg::OFFS_W-1:0];
                        tab_len[fs]   = len;
                        r.offset  = where[etff_pkg::OFFS_W-1:0];
                        r.granted = len;
                    end
                end
            end
        end
        else
        begin
            idx = lookup(k);
            if (idx < 0) r.status = etff_pkg::ST_NOT_FOUND;
            else drop(idx);
        end
        r.used = used_total();
        status_cnt[r.status]++;
        pending_q.push_back(r);
    endfunction

    function void note_failure(string msg);
        failures++;
        if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [etff_pkg::M_TDATA_W-1:0] word);
        extent_result_t want;
        extent_result_t got;
        string msg;
        got.status  = etff_pkg::status_t'(word[etff_pkg::M_STAT_LSB +: etff_pkg::STATUS_W]);
        got.offset  = word[etff_pkg::M_OFFS_LSB +: etff_pkg::OFFS_W];
        got.granted = word[etff_pkg::M_GRNT_LSB +: etff_pkg::LEN_W];
        got.used    = word[etff_pkg::M_USED_LSB +: etff_pkg::LEN_W];
        results_checked++;
        if (pending_q.size() == 0)
        begin
            note_failure($sformatf("result word %0d arrived with no request pending: %h",
                                   results_checked, word));
            return;
        end
        want = pending_q.pop_front();
        if (got.status !== want.status || got.offset !== want.offset ||
            got.granted !== want.granted || got.used !== want.used)
        begin
            msg = $sformatf("mismatch on result %0d: exp status=%0d offset=%0d",
                            results_checked, want.status, want.offset);
            msg = {msg, $sformatf(" granted=%0d used=%0d, got status=%0d offset=%0d",
                                  want.granted, want.used, got.status, got.offset)};
            msg = {msg, $sformatf(" granted=%0d used=%0d", got.granted, got.used)};
            note_failure(msg);
        end
    endfunction
endclass

module extent_table_first_fit_unit_tb;

    localparam int NSLOTS         = 16;
    localparam int AREA           = 4096;
    localparam int RANDOM_ITEMS   = 750;
    localparam int PLANNED_ITEMS  = RANDOM_ITEMS + 25;
    localparam int KEY_POOL       = 20;
    localparam int HOLD_CYCLES    = 300;
    // longest write: a full first-fit loop, plus the output register
    localparam int DRAIN_CYCLES   = 48;
    localparam int WATCHDOG_LIMIT = 5000;

    // directed keys, top byte live
    localparam logic [etff_pkg::KEY_W-1:0] KEY_A = 32'h4B45_5901;
    localparam logic [etff_pkg::KEY_W-1:0] KEY_B = 32'h0102_0304;
    localparam logic [etff_pkg::KEY_W-1:0] KEY_C = 32'hFE00_00FF;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [etff_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [etff_pkg::M_TDATA_W-1:0] m_tdata;

    extent_scoreboard #(NSLOTS, AREA) sb;

    int send_idle_pct = 28;
    int recv_idle_pct = 70;
    bit pressure_armed = 1'b0;
    bit pressure_done  = 1'b0;
    int hold_left      = 0;
    int items_sent     = 0;
    int idle_cycles    = 0;
    int stall_cycles   = 0;
    logic [etff_pkg::KEY_W-1:0] key_pool [KEY_POOL];

    extent_table_first_fit_unit #(
        .SLOTS      (NSLOTS),
        .AREA_BYTES (AREA)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one request word and hold it until the block takes it.
    // The idle mix follows the run's progress: receiver-heavy gaps first,
    // then sender-heavy, then full rate with one long back-pressure stretch.
    task automatic send_request(etff_pkg::func_t f, logic [etff_pkg::KEY_W-1:0] k,
                                logic [etff_pkg::LEN_W-1:0] len);
        logic [etff_pkg::S_TDATA_W-1:0] word;
        word = '0;
        word[etff_pkg::S_FUNC_LSB +: etff_pkg::FUNC_W] = f;
        word[etff_pkg::S_KEY_LSB +: etff_pkg::KEY_W]   = k;
        word[etff_pkg::S_LEN_LSB +: etff_pkg::LEN_W]   = len;
        if (items_sent < PLANNED_ITEMS / 3)
        begin
            send_idle_pct = 28;
            recv_idle_pct = 70;
        end
        else if (items_sent < 2 * PLANNED_ITEMS / 3)
        begin
            send_idle_pct = 70;
            recv_idle_pct = 28;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            pressure_armed = 1'b1;
        end
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        sb.note_request(f, k, len);
        items_sent++;
    endtask

    // Receiver: random ready, except for one long hold-off once armed
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (pressure_armed && !pressure_done)
            begin
                pressure_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Check every result word taken on the master side
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (hold_left > 0 && s_tvalid && !s_tready) stall_cycles++;
    end

    // Watchdog: end the run when no word moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int n;
        int ep_len;
        int pick;
        int size_class;
        etff_pkg::func_t f;
        logic [etff_pkg::KEY_W-1:0] k;
        logic [etff_pkg::LEN_W-1:0] len;

        sb = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = {8'($urandom_range(1, 254)), 24'($urandom)};
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: rejected requests first, then a small placed layout
        send_request(etff_pkg::FUNC_CLEAR,  32'h0000_0000, 16'd0);
        send_request(etff_pkg::FUNC_READ,   KEY_A,         16'd16);    // not found
        send_request(etff_pkg::FUNC_WRITE,  32'h00FF_FFFF, 16'd16);    // empty key byte
        send_request(etff_pkg::FUNC_READ,   32'hFFFF_FFFF, 16'hFFFF);  // erased key byte
        send_request(etff_pkg::FUNC_REMOVE, 32'hFF00_0000, 16'd0);     // erased key byte
        send_request(etff_pkg::FUNC_WRITE,  KEY_A,         16'd0);     // zero length
        send_request(etff_pkg::FUNC_WRITE,  KEY_A,         16'(AREA + 1));
        send_request(etff_pkg::FUNC_WRITE,  KEY_A,         16'hFFFF);
        send_request(etff_pkg::FUNC_READ,   KEY_A,         16'd0);     // zero length read
        send_request(etff_pkg::FUNC_WRITE,  KEY_A,         16'd100);
        send_request(etff_pkg::FUNC_WRITE,  KEY_B,         16'd200);
        send_request(etff_pkg::FUNC_WRITE,  KEY_C,         16'd50);
        send_request(etff_pkg::FUNC_READ,   KEY_A,         16'hFFFF);  // clipped to size
        send_request(etff_pkg::FUNC_READ,   KEY_B,         16'd7);     // clipped to buffer
        send_request(etff_pkg::FUNC_WRITE,  KEY_A,         16'd60);    // shrink in place
        send_request(etff_pkg::FUNC_WRITE,  KEY_B,         16'd300);   // relocate, jumps
        send_request(etff_pkg::FUNC_REMOVE, KEY_C,         16'hFFFF);
        send_request(etff_pkg::FUNC_REMOVE, KEY_C,         16'd0);     // already gone
        send_request(etff_pkg::FUNC_WRITE,  KEY_C,         16'(AREA)); // no gap left
        send_request(etff_pkg::FUNC_CLEAR,  32'hFFFF_FFFF, 16'hFFFF);
        send_request(etff_pkg::FUNC_WRITE,  KEY_A,         16'd4000);
        send_request(etff_pkg::FUNC_WRITE,  KEY_B,         16'd96);    // fills the tail
        send_request(etff_pkg::FUNC_WRITE,  KEY_B,         16'd97);    // dropped, no room
        send_request(etff_pkg::FUNC_READ,   KEY_B,         16'd1);     // stays dropped
        send_request(etff_pkg::FUNC_REMOVE, KEY_A,         16'd0);

        // Random part: episodes from an empty table, each with a size class.
        // Small sizes run out of slots, large sizes run out of area.
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            size_class = $urandom_range(0, 2);
            send_request(etff_pkg::FUNC_CLEAR, $urandom, 16'($urandom));
            n++;
            ep_len = $urandom_range(20, 60);
            for (int j = 0; j < ep_len && n < RANDOM_ITEMS; j++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)      f = etff_pkg::FUNC_WRITE;
                else if (pick < 75) f = etff_pkg::FUNC_READ;
                else if (pick < 97) f = etff_pkg::FUNC_REMOVE;
                else                f = etff_pkg::FUNC_CLEAR;

                pick = $urandom_range(0, 99);
                if (pick < 88)
                    k = key_pool[$urandom_range(0, KEY_POOL - 1)];
                else if (pick < 94)
                    k = $urandom;
                else
                    k = {($urandom_range(0, 1) ? etff_pkg::KEY_BYTE_ERASED
                                               : etff_pkg::KEY_BYTE_EMPTY),
                         24'($urandom)};

                pick = $urandom_range(0, 99);
                if (pick < 85)
                begin
                    if (size_class == 0)      len = 16'($urandom_range(1, 40));
                    else if (size_class == 1) len = 16'($urandom_range(1, 600));
                    else                      len = 16'($urandom_range(200, AREA));
                end
                else if (pick < 91)
                begin
                    len = 16'($urandom_range(1, AREA));
                end
                else if (pick < 95)
                begin
                    len = 16'd0;
                end
                else if (pick < 98)
                begin
                    len = 16'($urandom_range(AREA + 1, 65535));
                end
                else
                begin
                    len = 16'(AREA);
                end
                send_request(f, k, len);
                n++;
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        // Drain: wait for every pending result, then watch for strays
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests (%0d rd, %0d wr, %0d rm, %0d clr), %0d results checked",
                 items_sent, sb.func_cnt[etff_pkg::FUNC_READ],
                 sb.func_cnt[etff_pkg::FUNC_WRITE], sb.func_cnt[etff_pkg::FUNC_REMOVE],
                 sb.func_cnt[etff_pkg::FUNC_CLEAR], sb.results_checked);
        $display("%0d ok, %0d invalid, %0d not found, %0d no space; %0d jumps max; %0d stalls",
                 sb.status_cnt[etff_pkg::ST_OK], sb.status_cnt[etff_pkg::ST_INVALID],
                 sb.status_cnt[etff_pkg::ST_NOT_FOUND], sb.status_cnt[etff_pkg::ST_NO_SPACE],
                 sb.deepest_jumps, stall_cycles);
        if (sb.failures == 0 && sb.pending_q.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("%0d failures, %0d results missing", sb.failures, sb.pending_q.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
